// File: src/bresenham_line_pixel_generator_defines.svh
// assertion macros for the line pixel generator
// used by the queue and back-end modules; no other dependencies
`ifndef BRESENHAM_LINE_PIXEL_GENERATOR_DEFINES_SVH
`define BRESENHAM_LINE_PIXEL_GENERATOR_DEFINES_SVH

// same-cycle implication
`define BLPG_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BLPG_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/blpg_pkg.sv
// shared types and codes of the line pixel generator
// no dependencies
package blpg_pkg;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_STEP = 1'b1
  } action_e;

  typedef enum logic {
    CFG_FRAME_WIDTH = 1'b0,
    CFG_TOP_ROW     = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// File: src/blpg_fifo.sv
// small synchronous queue with level output
// depends on blpg_pkg and the assertion macro header
`include "bresenham_line_pixel_generator_defines.svh"

module blpg_fifo import blpg_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             pop_i,
  output logic [WIDTH-1:0]                 rdata_o,
  output fifo_stat_t                       stat_o,
  output logic [$clog2(DEPTH+1)-1:0]       level_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned LW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [LW-1:0]    level_q, level_d;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_comb begin
    level_d = level_q;
    if (push_i && !pop_i) begin
      level_d = level_q + LW'(1);
    end else if (pop_i && !push_i) begin
      level_d = level_q - LW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + AW'(1);
      end
      level_q <= level_d;
    end
  end

  assign rdata_o      = mem_q[rd_ptr_q];
  assign stat_o.full  = (level_q == LW'(DEPTH));
  assign stat_o.empty = (level_q == '0);
  assign level_o      = level_q;

  `BLPG_ASSERT_IMP(a_no_overflow, clk_i, rst_ni, push_i, !stat_o.full, "push into full queue")
  `BLPG_ASSERT_IMP(a_no_underflow, clk_i, rst_ni, pop_i, !stat_o.empty, "pop from empty queue")
  `BLPG_ASSERT_NXT(a_level_track, clk_i, rst_ni, push_i && !pop_i, level_o == $past(level_o) + LW'(1), "queue level lost a push")

endmodule

// File: src/blpg_front.sv
// front end: accepts items, classifies loads and precomputes the octant setup
// depends on blpg_pkg
module blpg_front import blpg_pkg::*; #(
  parameter int unsigned COORD_BITS = 10,
  parameter int unsigned COLOR_BITS = 8
) (
  input  logic                  push_i,
  input  fifo_stat_t            cmd_stat_i,
  input  logic                  action_i,
  input  logic [COORD_BITS-1:0] x_start_i,
  input  logic [COORD_BITS-1:0] y_start_i,
  input  logic [COORD_BITS-1:0] x_end_i,
  input  logic [COORD_BITS-1:0] y_end_i,
  input  logic [COLOR_BITS-1:0] color_i,
  output logic                  cmd_push_o,
  output logic [3+4*COORD_BITS+3*(COORD_BITS+4)+COLOR_BITS-1:0] cmd_o
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned EW = COORD_BITS + 4;

  typedef struct packed {
    logic                 is_load;
    logic                 ok;
    logic                 desc;
    logic [CB-1:0]        xs;
    logic [CB-1:0]        ys;
    logic [CB-1:0]        xe;
    logic [CB-1:0]        ye;
    logic signed [EW-1:0] err0;
    logic signed [EW-1:0] inc_diag;
    logic signed [EW-1:0] inc_flat;
    logic [COLOR_BITS-1:0] color;
  } cmd_t;

  logic signed [CB+1:0] dx, dy, neg_dy;
  logic signed [EW-1:0] dx_e, dy_e;
  cmd_t                 cmd;

  always_comb begin
    dx     = signed'({2'b00, x_end_i}) - signed'({2'b00, x_start_i});
    dy     = signed'({2'b00, y_end_i}) - signed'({2'b00, y_start_i});
    neg_dy = -dy;
    dx_e   = EW'(dx);
    dy_e   = EW'(dy);

    cmd.is_load = (action_e'(action_i) == ACT_LOAD);
    cmd.desc    = dy[CB+1];
    // slope must stay within [-1, 1] and the line must run to the right
    cmd.ok      = (dx > 0) && ((!dy[CB+1] && (dy <= dx)) || (dy[CB+1] && (neg_dy <= dx)));
    cmd.xs      = x_start_i;
    cmd.ys      = y_start_i;
    cmd.xe      = x_end_i;
    cmd.ye      = y_end_i;
    cmd.inc_flat = dy_e + dy_e;
    if (dy[CB+1]) begin
      cmd.err0     = dy_e + dy_e + dx_e;
      cmd.inc_diag = dy_e + dy_e + dx_e + dx_e;
    end else begin
      cmd.err0     = dy_e + dy_e - dx_e;
      cmd.inc_diag = dy_e + dy_e - dx_e - dx_e;
    end
    cmd.color = color_i;
  end

  assign cmd_push_o = push_i && !cmd_stat_i.full;
  assign cmd_o      = cmd;

endmodule

// File: src/blpg_back.sv
// back end: holds the active line, steps the error term, forms the address
// depends on blpg_pkg and the assertion macro header
`include "bresenham_line_pixel_generator_defines.svh"

module blpg_back import blpg_pkg::*; #(
  parameter int unsigned COORD_BITS = 10,
  parameter int unsigned COLOR_BITS = 8,
  parameter int unsigned OUT_DEPTH  = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [COORD_BITS:0]   frame_width_i,
  input  logic [COORD_BITS-1:0] top_row_i,
  input  fifo_stat_t            cmd_stat_i,
  input  logic [3+4*COORD_BITS+3*(COORD_BITS+4)+COLOR_BITS-1:0] cmd_i,
  output logic                  cmd_pop_o,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_level_i,
  output logic                  out_push_o,
  output logic [4*COORD_BITS+COLOR_BITS+2-1:0] out_data_o
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned EW = COORD_BITS + 4;
  localparam int unsigned LW = $clog2(OUT_DEPTH+1);

  typedef struct packed {
    logic                 is_load;
    logic                 ok;
    logic                 desc;
    logic [CB-1:0]        xs;
    logic [CB-1:0]        ys;
    logic [CB-1:0]        xe;
    logic [CB-1:0]        ye;
    logic signed [EW-1:0] err0;
    logic signed [EW-1:0] inc_diag;
    logic signed [EW-1:0] inc_flat;
    logic [COLOR_BITS-1:0] color;
  } cmd_t;

  typedef struct packed {
    logic [CB-1:0]         px;
    logic [CB-1:0]         py;
    logic [2*CB-1:0]       addr;
    logic [COLOR_BITS-1:0] color;
    logic                  in_frame;
    logic                  last;
  } pix_t;

  cmd_t cmd;

  // line state
  logic                  active_q, desc_q;
  logic [CB:0]           cx_q;
  logic signed [CB+1:0]  cy_q;
  logic [CB-1:0]         ex_q, ey_q;
  logic signed [EW-1:0]  err_q, inc_diag_q, inc_flat_q;
  logic [COLOR_BITS-1:0] color_q;

  // pixel stage ahead of the output queue
  logic                  a_valid_q;
  logic [CB-1:0]         a_px_q, a_py_q, a_row_q;
  logic [COLOR_BITS-1:0] a_color_q;
  logic                  a_inside_q, a_last_q;

  logic                 need_out, credit, step_fire;
  logic                 take;
  logic [CB:0]          nx;
  logic signed [CB+1:0] ny, ey_s;
  logic signed [EW-1:0] err_d;
  logic                 more, in_frame;
  logic [LW:0]          in_flight;
  logic [2*CB:0]        prod;
  pix_t                 pix;

  assign cmd = cmd_t'(cmd_i);

  always_comb begin
    need_out  = !cmd.is_load && active_q;
    in_flight = {1'b0, out_level_i} + (LW+1)'(a_valid_q);
    credit    = in_flight < (LW+1)'(OUT_DEPTH);
    cmd_pop_o = !cmd_stat_i.empty && (!need_out || credit);
    step_fire = cmd_pop_o && need_out;
  end

  always_comb begin
    // descending line moves down while the error is not positive
    take  = desc_q ? (err_q[EW-1] || (err_q == '0)) : !err_q[EW-1];
    err_d = err_q + (take ? inc_diag_q : inc_flat_q);
    nx    = cx_q + (CB+1)'(1);
    ny    = cy_q;
    if (take) begin
      ny = desc_q ? cy_q - (CB+2)'(1) : cy_q + (CB+2)'(1);
    end
    ey_s     = signed'({2'b00, ey_q});
    more     = (nx <= {1'b0, ex_q}) && (desc_q ? (ny >= ey_s) : (ny <= ey_s));
    in_frame = (cy_q[CB-1:0] <= top_row_i) && ({1'b0, cx_q[CB-1:0]} < frame_width_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      desc_q     <= 1'b0;
      cx_q       <= '0;
      cy_q       <= '0;
      ex_q       <= '0;
      ey_q       <= '0;
      err_q      <= '0;
      inc_diag_q <= '0;
      inc_flat_q <= '0;
      color_q    <= '0;
      a_valid_q  <= 1'b0;
    end else begin
      a_valid_q <= step_fire;
      if (cmd_pop_o && cmd.is_load) begin
        active_q <= cmd.ok;
        if (cmd.ok) begin
          desc_q     <= cmd.desc;
          cx_q       <= {1'b0, cmd.xs};
          cy_q       <= signed'({2'b00, cmd.ys});
          ex_q       <= cmd.xe;
          ey_q       <= cmd.ye;
          err_q      <= cmd.err0;
          inc_diag_q <= cmd.inc_diag;
          inc_flat_q <= cmd.inc_flat;
          color_q    <= cmd.color;
        end
      end else if (step_fire) begin
        active_q <= more;
        cx_q     <= nx;
        cy_q     <= ny;
        err_q    <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      a_px_q     <= cx_q[CB-1:0];
      a_py_q     <= cy_q[CB-1:0];
      a_row_q    <= top_row_i - cy_q[CB-1:0];
      a_color_q  <= color_q;
      a_inside_q <= in_frame;
      a_last_q   <= !more;
    end
  end

  always_comb begin
    prod         = {{(CB+1){1'b0}}, a_row_q} * {{CB{1'b0}}, frame_width_i};
    pix.px       = a_px_q;
    pix.py       = a_py_q;
    pix.addr     = a_inside_q ? (prod[2*CB-1:0] + {{CB{1'b0}}, a_px_q}) : '0;
    pix.color    = a_color_q;
    pix.in_frame = a_inside_q;
    pix.last     = a_last_q;
  end

  assign out_push_o = a_valid_q;
  assign out_data_o = pix;

  `BLPG_ASSERT_NXT(a_last_ends_line, clk_i, rst_ni, step_fire && !more, !active_q, "line still active after last pixel")
  `BLPG_ASSERT_NXT(a_step_makes_pixel, clk_i, rst_ni, step_fire, a_valid_q, "step lost its pixel")
  `BLPG_ASSERT_NXT(a_idle_no_pixel, clk_i, rst_ni, !step_fire, !a_valid_q, "pixel without an active step")

endmodule

// File: src/bresenham_line_pixel_generator.sv
// Line pixel generator for slopes in [-1, 1] with x running left to right.
// Input channel (push/full): action 0 loads endpoints and a color; a line that
// runs right-to-left, is vertical or steeper than 45 degrees is dropped and
// leaves no line active. Action 1 emits the next pixel of the active line;
// with no active line it emits nothing. Loads never emit.
// Result channel (empty/pop): pixel coordinates, frame-buffer address
// (top_row - y) * frame_width + x, color, in-frame flag and last flag. The
// address reads zero when the pixel lies outside the frame.
// Throughput: one item per cycle sustained while the result queue has room;
// the error-term add and compare runs once per cycle in the back end, and
// the address multiply has a stage of its own. A pixel passes the back-end
// pixel stage and then the result queue before it shows on the result side.
// A four-entry command queue sits between the front and back ends, and a
// four-entry result queue at the output; when the receiver stops popping the
// result queue fills, the back end stalls, then full rises on the input.
// Reset clears both queues and the active line; frame_width resets to
// 2^COORD_BITS and top_row to 2^COORD_BITS-1. Write registers only while idle.
// Depends on blpg_pkg, blpg_fifo, blpg_front and blpg_back.
module bresenham_line_pixel_generator import blpg_pkg::*; #(
  parameter int unsigned COORD_BITS = 10,
  parameter int unsigned COLOR_BITS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  logic                    action_i,
  input  logic [COORD_BITS-1:0]   x_start_i,
  input  logic [COORD_BITS-1:0]   y_start_i,
  input  logic [COORD_BITS-1:0]   x_end_i,
  input  logic [COORD_BITS-1:0]   y_end_i,
  input  logic [COLOR_BITS-1:0]   color_i,
  output logic                    empty,
  input  logic                    pop,
  output logic [COORD_BITS-1:0]   pixel_x_o,
  output logic [COORD_BITS-1:0]   pixel_y_o,
  output logic [2*COORD_BITS-1:0] pixel_address_o,
  output logic [COLOR_BITS-1:0]   pixel_color_o,
  output logic                    in_frame_o,
  output logic                    last_o,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [COORD_BITS:0]     cfg_data_i
);

  localparam int unsigned CB        = COORD_BITS;
  localparam int unsigned EW        = COORD_BITS + 4;
  localparam int unsigned CMD_W     = 3 + 4*CB + 3*EW + COLOR_BITS;
  localparam int unsigned PIX_W     = 4*CB + COLOR_BITS + 2;
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned OUT_DEPTH = 4;

  typedef struct packed {
    logic [CB-1:0]         px;
    logic [CB-1:0]         py;
    logic [2*CB-1:0]       addr;
    logic [COLOR_BITS-1:0] color;
    logic                  in_frame;
    logic                  last;
  } pix_t;

  logic [CB:0]   frame_width_q;
  logic [CB-1:0] top_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q <= {1'b1, {CB{1'b0}}};
      top_row_q     <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FRAME_WIDTH: frame_width_q <= cfg_data_i;
        CFG_TOP_ROW:     top_row_q     <= cfg_data_i[CB-1:0];
      endcase
    end
  end

  fifo_stat_t                      cmd_stat, out_stat;
  logic                            cmd_push, cmd_pop, out_push;
  logic [CMD_W-1:0]                cmd_wdata, cmd_rdata;
  logic [PIX_W-1:0]                out_wdata, out_rdata;
  logic [$clog2(CMD_DEPTH+1)-1:0]  cmd_level;
  logic [$clog2(OUT_DEPTH+1)-1:0]  out_level;
  pix_t                            pix;

  blpg_front #(
    .COORD_BITS(COORD_BITS),
    .COLOR_BITS(COLOR_BITS)
  ) u_front (
    .push_i     (push),
    .cmd_stat_i (cmd_stat),
    .action_i   (action_i),
    .x_start_i  (x_start_i),
    .y_start_i  (y_start_i),
    .x_end_i    (x_end_i),
    .y_end_i    (y_end_i),
    .color_i    (color_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_wdata)
  );

  blpg_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_wdata),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_rdata),
    .stat_o  (cmd_stat),
    .level_o (cmd_level)
  );

  blpg_back #(
    .COORD_BITS(COORD_BITS),
    .COLOR_BITS(COLOR_BITS),
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_width_i (frame_width_q),
    .top_row_i     (top_row_q),
    .cmd_stat_i    (cmd_stat),
    .cmd_i         (cmd_rdata),
    .cmd_pop_o     (cmd_pop),
    .out_level_i   (out_level),
    .out_push_o    (out_push),
    .out_data_o    (out_wdata)
  );

  blpg_fifo #(
    .WIDTH(PIX_W),
    .DEPTH(OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (out_wdata),
    .pop_i   (pop && !out_stat.empty),
    .rdata_o (out_rdata),
    .stat_o  (out_stat),
    .level_o (out_level)
  );

  assign pix             = pix_t'(out_rdata);
  // the command queue level also shows the front end is never blocked when empty
  assign full            = cmd_stat.full && (cmd_level != '0);
  assign empty           = out_stat.empty;
  assign pixel_x_o       = pix.px;
  assign pixel_y_o       = pix.py;
  assign pixel_address_o = pix.addr;
  assign pixel_color_o   = pix.color;
  assign in_frame_o      = pix.in_frame;
  assign last_o          = pix.last;

endmodule
